>>> design/tcpws_pkg.sv
`timescale 1ns / 1ps

package tcpws_pkg;

    localparam int MAX_OPTION_BYTES = 40;

    // Body bytes still owed never exceed MAX_OPTION_BYTES - 2.
    localparam int LEFT_W = (MAX_OPTION_BYTES > 3) ? $clog2(MAX_OPTION_BYTES - 1) : 1;

    localparam logic [7:0] MAX_LEN     = 8'(MAX_OPTION_BYTES);
    localparam logic [7:0] MIN_LEN     = 8'd2;
    localparam logic [7:0] KIND_END    = 8'd0;
    localparam logic [7:0] KIND_NOP    = 8'd1;
    localparam logic [7:0] KIND_WSCALE = 8'd3;
    localparam logic [7:0] WSCALE_LEN  = 8'd3;

    typedef struct packed {
        logic [7:0] option_byte;
        logic       last_byte;
        logic       area_empty;
    } item_t;

    typedef struct packed {
        logic       scale_present;
        logic [7:0] scale_shift;
        logic       parse_error;
    } result_t;

endpackage

>>> design/tcpws_parse.sv
`timescale 1ns / 1ps

module tcpws_parse (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               step,
    input  tcpws_pkg::item_t   item,
    output tcpws_pkg::result_t result
);

    typedef enum logic [1:0] {
        PH_KIND,
        PH_LEN,
        PH_BODY,
        PH_DONE
    } phase_t;

    phase_t                      phase_reg, phase_next;
    logic                        kind_ws_reg, kind_ws_next;
    logic [tcpws_pkg::LEFT_W-1:0] left_reg, left_next;
    logic                        cand_reg, cand_next;
    logic [7:0]                  shift_reg, shift_next;
    logic                        seen_reg, seen_next;
    logic                        err_reg, err_next;

    logic [7:0] b;
    logic       last;

    assign b    = item.option_byte;
    assign last = item.last_byte;

    always_comb begin
        phase_next   = phase_reg;
        kind_ws_next = kind_ws_reg;
        left_next    = left_reg;
        cand_next    = cand_reg;
        shift_next   = shift_reg;
        seen_next    = seen_reg;
        err_next     = err_reg;

        unique case (phase_reg)
            PH_KIND: begin
                if (b == tcpws_pkg::KIND_END) begin
                    phase_next = PH_DONE;
                end else if (b != tcpws_pkg::KIND_NOP) begin
                    kind_ws_next = (b == tcpws_pkg::KIND_WSCALE);
                    if (last) begin
                        err_next   = 1'b1;
                        phase_next = PH_DONE;
                    end else begin
                        phase_next = PH_LEN;
                    end
                end
            end
            PH_LEN: begin
                if (b < tcpws_pkg::MIN_LEN || b > tcpws_pkg::MAX_LEN) begin
                    err_next   = 1'b1;
                    phase_next = PH_DONE;
                end else begin
                    left_next = tcpws_pkg::LEFT_W'(b - tcpws_pkg::MIN_LEN);
                    cand_next = kind_ws_reg && (b == tcpws_pkg::WSCALE_LEN);
                    if (b == tcpws_pkg::MIN_LEN) begin
                        phase_next = PH_KIND;
                    end else if (last) begin
                        err_next   = 1'b1;
                        phase_next = PH_DONE;
                    end else begin
                        phase_next = PH_BODY;
                    end
                end
            end
            PH_BODY: begin
                if (cand_reg) begin
                    shift_next = b;
                    seen_next  = 1'b1;
                    cand_next  = 1'b0;
                end
                left_next = left_reg - 1'b1;
                if (left_reg == tcpws_pkg::LEFT_W'(1)) begin
                    phase_next = PH_KIND;
                end else if (last) begin
                    err_next   = 1'b1;
                    phase_next = PH_DONE;
                end
            end
            default: begin
                phase_next = PH_DONE;
            end
        endcase
    end

    always_comb begin
        result.scale_present = seen_next && !item.area_empty;
        result.scale_shift   = (seen_next && !item.area_empty) ? shift_next : 8'd0;
        result.parse_error   = err_next && !item.area_empty;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (step && (item.area_empty || item.last_byte))) begin
            phase_reg   <= PH_KIND;
            kind_ws_reg <= 1'b0;
            left_reg    <= '0;
            cand_reg    <= 1'b0;
            shift_reg   <= 8'd0;
            seen_reg    <= 1'b0;
            err_reg     <= 1'b0;
        end else if (step) begin
            phase_reg   <= phase_next;
            kind_ws_reg <= kind_ws_next;
            left_reg    <= left_next;
            cand_reg    <= cand_next;
            shift_reg   <= shift_next;
            seen_reg    <= seen_next;
            err_reg     <= err_next;
        end
    end

endmodule

>>> design/tcp_option_window_scale_parser.sv
`timescale 1ns / 1ps

// Parses a TCP options area presented one byte per transfer and reports the window scale
// option. Each byte is taken into an input register, then runs through a small parse state
// update, and the report for an area is loaded into an output register on the
// byte marked by s_tlast (or on a transfer with the empty-area flag in s_tuser). The block
// accepts one byte per cycle unless a pending report holds it back, and the report is valid
// once the final byte has moved from the input register into the output register; a report
// that is not taken stalls the input only when another report is about to be made.

module tcp_option_window_scale_parser (
    input  logic       aclk,
    input  logic       aresetn,

    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] option_byte
    input  logic       s_tlast,   // last_byte
    input  logic       s_tuser,   // [0] area_empty

    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] scale_shift
    output logic [1:0] m_tuser    // [0] scale_present, [1] parse_error
);

    logic               in_valid_reg;
    tcpws_pkg::item_t   in_item_reg;
    logic               out_valid_reg;
    tcpws_pkg::result_t out_result_reg;

    tcpws_pkg::result_t result;
    logic               reports;
    logic               advance;

    assign reports  = in_item_reg.area_empty || in_item_reg.last_byte;
    assign advance  = in_valid_reg && (!reports || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    tcpws_parse u_parse (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .item    (in_item_reg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg.option_byte <= s_tdata;
            in_item_reg.last_byte   <= s_tlast;
            in_item_reg.area_empty  <= s_tuser;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && reports) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && reports) begin
            out_result_reg <= result;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_result_reg.scale_shift;
    assign m_tuser[0] = out_result_reg.scale_present;
    assign m_tuser[1] = out_result_reg.parse_error;

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 400;
    localparam int RANDOM_ITEMS = 1350;

    typedef enum logic [2:0] {PH_KIND, PH_LEN, PH_BODY, PH_DONE} parse_phase_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'd0;
    logic       s_tlast = 1'b0;
    logic       s_tuser = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic [1:0] m_tuser;

    tcp_option_window_scale_parser DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 aclk = ~aclk;

    tcpws_pkg::item_t   option_stream[$];
    tcpws_pkg::result_t expected_reports[$];
    logic [7:0]         area_bytes[$];
    int                 items_queued = 0;
    int                 items_accepted = 0;
    int                 errors = 0;
    int                 cycles = 0;
    int                 send_idle_pct = 0;
    int                 recv_stall_pct = 0;
    int                 hold_req = 0;
    int                 hold_ack = 0;
    int                 hold_left = 0;
    logic               in_taken = 1'b0;
    tcpws_pkg::item_t   offered;

    parse_phase_t phase = PH_KIND;
    logic [7:0]   cur_kind = 8'd0;
    logic [7:0]   body_left = 8'd0;
    logic         ws_pending = 1'b0;
    logic [7:0]   shift_held = 8'd0;
    logic         shift_seen = 1'b0;
    logic         err_seen = 1'b0;

    function automatic void restart_area();
        phase = PH_KIND;
        cur_kind = 8'd0;
        body_left = 8'd0;
        ws_pending = 1'b0;
        shift_held = 8'd0;
        shift_seen = 1'b0;
        err_seen = 1'b0;
    endfunction

    function automatic void abort_area();
        err_seen = 1'b1;
        phase = PH_DONE;
    endfunction

    // Advances the parse by one transfer and returns 1 when it closes an area.
    function automatic bit parse_option_byte(input tcpws_pkg::item_t it,
                                             output tcpws_pkg::result_t rep);
        logic [7:0] b;
        b = it.option_byte;
        rep = '0;
        if (it.area_empty) begin
            restart_area();
            return 1'b1;
        end
        case (phase)
            PH_KIND: begin
                if (b == tcpws_pkg::KIND_END) begin
                    phase = PH_DONE;
                end else if (b != tcpws_pkg::KIND_NOP) begin
                    cur_kind = b;
                    if (it.last_byte) abort_area();
                    else phase = PH_LEN;
                end
            end
            PH_LEN: begin
                if (b < tcpws_pkg::MIN_LEN || b > tcpws_pkg::MAX_LEN) begin
                    abort_area();
                end else begin
                    body_left = b - tcpws_pkg::MIN_LEN;
                    ws_pending = (cur_kind == tcpws_pkg::KIND_WSCALE) &&
                                 (b == tcpws_pkg::WSCALE_LEN);
                    if (body_left == 8'd0) phase = PH_KIND;
                    else if (it.last_byte) abort_area();
                    else phase = PH_BODY;
                end
            end
            PH_BODY: begin
                if (ws_pending) begin
                    shift_held = b;
                    shift_seen = 1'b1;
                    ws_pending = 1'b0;
                end
                body_left = body_left - 8'd1;
                if (body_left == 8'd0) phase = PH_KIND;
                else if (it.last_byte) abort_area();
            end
            default: phase = PH_DONE;
        endcase
        if (!it.last_byte) return 1'b0;
        rep.scale_present = shift_seen;
        rep.scale_shift = shift_seen ? shift_held : 8'd0;
        rep.parse_error = err_seen;
        restart_area();
        return 1'b1;
    endfunction

    task automatic push_item(input logic [7:0] b, input logic last, input logic empty);
        tcpws_pkg::item_t it;
        it.option_byte = b;
        it.last_byte = last;
        it.area_empty = empty;
        option_stream.push_back(it);
        items_queued++;
    endtask

    task automatic push_empty();
        push_item(8'($urandom), 1'($urandom), 1'b1);
    endtask

    // Sends the collected area; when abandoned, an empty-area transfer cuts it short.
    task automatic emit_area(input bit abandon);
        int n;
        n = area_bytes.size();
        if (abandon && n > 1) n = $urandom_range(1, n - 1);
        for (int i = 0; i < n; i++) begin
            push_item(area_bytes[i], !abandon && (i == n - 1), 1'b0);
        end
        if (abandon) push_empty();
        area_bytes.delete();
    endtask

    task automatic build_random_area();
        int sel;
        int len;
        logic [7:0] kind;
        sel = $urandom_range(0, 99);
        area_bytes.delete();
        if (sel < 8) begin
            repeat ($urandom_range(1, 8)) area_bytes.push_back(8'($urandom));
            return;
        end
        repeat ($urandom_range(0, 5)) begin
            case ($urandom_range(0, 9))
                0, 1: area_bytes.push_back(tcpws_pkg::KIND_NOP);
                2, 3, 4: begin
                    area_bytes.push_back(tcpws_pkg::KIND_WSCALE);
                    area_bytes.push_back(tcpws_pkg::WSCALE_LEN);
                    if ($urandom_range(0, 3) == 0) area_bytes.push_back(8'($urandom));
                    else area_bytes.push_back(8'($urandom_range(0, 14)));
                end
                default: begin
                    kind = 8'($urandom_range(2, 255));
                    if ($urandom_range(0, 19) == 0)
                        len = $urandom_range(2, tcpws_pkg::MAX_OPTION_BYTES);
                    else
                        len = $urandom_range(2, 10);
                    area_bytes.push_back(kind);
                    area_bytes.push_back(8'(len));
                    repeat (len - 2) area_bytes.push_back(8'($urandom));
                end
            endcase
        end
        if (area_bytes.size() == 0 || $urandom_range(0, 6) == 0) begin
            area_bytes.push_back(tcpws_pkg::KIND_END);
            repeat ($urandom_range(0, 3)) area_bytes.push_back(8'($urandom));
        end
        if (sel >= 70) begin
            case ($urandom_range(0, 2))
                0: repeat ($urandom_range(0, area_bytes.size() - 1)) void'(area_bytes.pop_back());
                1: area_bytes.push_back(8'($urandom_range(2, 255)));
                default: begin
                    area_bytes.push_back(8'($urandom_range(2, 255)));
                    if ($urandom_range(0, 1) == 0)
                        area_bytes.push_back(8'($urandom_range(0, 1)));
                    else
                        area_bytes.push_back(
                            8'($urandom_range(tcpws_pkg::MAX_OPTION_BYTES + 1, 255)));
                    repeat ($urandom_range(0, 3)) area_bytes.push_back(8'($urandom));
                end
            endcase
        end
    endtask

    task automatic queue_random_items(input int count);
        int target;
        target = items_queued + count;
        while (items_queued < target) begin
            if ($urandom_range(0, 24) == 0) begin
                push_empty();
            end else begin
                build_random_area();
                emit_area($urandom_range(0, 29) == 0);
            end
        end
    endtask

    task automatic wait_stream_drained();
        while (option_stream.size() != 0) @(posedge aclk);
    endtask

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_taken) begin
            if (option_stream.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                offered = option_stream.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= offered.option_byte;
                s_tlast <= offered.last_byte;
                s_tuser <= offered.area_empty;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        if (hold_req != hold_ack) begin
            hold_ack <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin : monitor
        tcpws_pkg::result_t want;
        tcpws_pkg::result_t rep;
        tcpws_pkg::item_t   it;
        if (!aresetn) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= s_tvalid && s_tready;
            if (m_tvalid && m_tready) begin
                if (expected_reports.size() == 0) begin
                    $error("report transfer with none expected: shift %0d, flags %b",
                           m_tdata, m_tuser);
                    errors++;
                end else begin
                    want = expected_reports.pop_front();
                    if (m_tuser[0] !== want.scale_present) begin
                        $error("scale_present: expected %0d, actual %0d",
                               want.scale_present, m_tuser[0]);
                        errors++;
                    end
                    if (m_tdata !== want.scale_shift) begin
                        $error("scale_shift: expected %0d, actual %0d", want.scale_shift, m_tdata);
                        errors++;
                    end
                    if (m_tuser[1] !== want.parse_error) begin
                        $error("parse_error: expected %0d, actual %0d",
                               want.parse_error, m_tuser[1]);
                        errors++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                items_accepted++;
                it.option_byte = s_tdata;
                it.last_byte = s_tlast;
                it.area_empty = s_tuser;
                if (parse_option_byte(it, rep)) expected_reports.push_back(rep);
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed areas: edge kinds, lengths and the malformed cases.
        push_empty();
        push_item(tcpws_pkg::KIND_END, 1'b1, 1'b0);
        push_item(tcpws_pkg::KIND_NOP, 1'b1, 1'b0);
        area_bytes = '{tcpws_pkg::KIND_WSCALE, tcpws_pkg::WSCALE_LEN, 8'd14};
        emit_area(1'b0);
        area_bytes = '{tcpws_pkg::KIND_WSCALE, tcpws_pkg::WSCALE_LEN, 8'd7,
                       tcpws_pkg::KIND_WSCALE, tcpws_pkg::WSCALE_LEN, 8'd255};
        emit_area(1'b0);
        push_item(8'd5, 1'b1, 1'b0);
        area_bytes = '{8'd2, 8'd1};
        emit_area(1'b0);
        area_bytes = '{8'd8, 8'd0};
        emit_area(1'b0);
        area_bytes = '{8'd8, tcpws_pkg::MAX_LEN + 8'd1, 8'hFF};
        emit_area(1'b0);
        area_bytes = '{tcpws_pkg::KIND_WSCALE, 8'd4, 8'hAA, 8'h55};
        emit_area(1'b0);
        area_bytes = '{tcpws_pkg::KIND_WSCALE, tcpws_pkg::WSCALE_LEN, 8'd9,
                       8'd4, 8'd5, 8'd1};
        emit_area(1'b0);
        area_bytes = '{tcpws_pkg::KIND_WSCALE, tcpws_pkg::WSCALE_LEN, 8'd5};
        emit_area(1'b1);
        wait_stream_drained();

        queue_random_items(RANDOM_ITEMS / 5);
        wait_stream_drained();

        send_idle_pct = 61;
        queue_random_items(RANDOM_ITEMS / 5);
        wait_stream_drained();

        send_idle_pct = 0;
        recv_stall_pct = 61;
        queue_random_items(RANDOM_ITEMS / 5);
        wait_stream_drained();

        send_idle_pct = 7;
        recv_stall_pct = 7;
        queue_random_items(RANDOM_ITEMS / 5);
        wait_stream_drained();

        // The receiver holds off while transfers keep coming, so the input backs up.
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_req = hold_req + 1;
        queue_random_items(RANDOM_ITEMS / 5);

        while (items_accepted != items_queued || expected_reports.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

>>> files.f
design/tcpws_pkg.sv
design/tcpws_parse.sv
design/tcp_option_window_scale_parser.sv
tb/tb_top.sv
